FILE: rtl/core/huffman_tree_decoder_unit_assert.svh
// Assertion macros shared by the Huffman tree decoder modules.
`ifndef HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define HTD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define HTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/htd_pkg.sv
// Shared types and constants of the Huffman tree decoder.
package htd_pkg;

  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int DATA_W    = 8;
  localparam int PAD_W     = 3;
  localparam int ACT_W     = 2;
  localparam int KIND_W    = 2;
  localparam int BYTE_BITS = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DECODE = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYMBOL     = 2'd0,
    KIND_BAD_PATH   = 2'd1,
    KIND_TABLE_FULL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_BIT,
    ST_LD_RD,
    ST_DEC_FETCH,
    ST_DEC_BIT,
    ST_DEC_RD,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  latch;
    logic  clear;
    logic  ld_start;
    logic  ld_alloc;
    logic  ld_descend;
    logic  ld_store;
    logic  ld_wb;
    logic  load_entry;
    logic  dec_start;
    logic  dec_skip;
    logic  dec_miss;
    logic  dec_descend;
    logic  dec_leaf;
    logic  emit;
    kind_t emit_kind;
    logic  flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_bad;
    logic walk_root;
    logic slot_zero;
    logic table_full;
    logic bits_zero;
    logic skip_nz;
    logic next_zero;
    logic rd_leaf;
    logic pend_valid;
    logic can_push;
  } sts_t;

endpackage

FILE: rtl/core/htd_if.sv
// Request channel interfaces of the Huffman tree decoder.
interface htd_in_if import htd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, action, symbol, code_bits, code_length, data_byte,
                  input ready);
  modport sink (input valid, action, symbol, code_bits, code_length, data_byte,
                output ready);
endinterface

interface htd_out_if import htd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol_res;
  logic              last;

  modport source (output valid, kind, symbol_res, last, input ready);
  modport sink (input valid, kind, symbol_res, last, output ready);
endinterface

interface htd_cfg_if import htd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PAD_W-1:0] padding_bits;

  modport source (output valid, padding_bits, input ready);
  modport sink (input valid, padding_bits, output ready);
endinterface

FILE: rtl/core/htd_ctrl.sv
// Controller state machine of the Huffman tree decoder.
module htd_ctrl import htd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  input  sts_t             sts,
  output cmd_t             cmd
);

  `include "huffman_tree_decoder_unit_assert.svh"

  state_t state_r;
  state_t state_nxt;
  logic   can_emit;

  assign can_emit = !sts.pend_valid || sts.can_push;
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = KIND_SYMBOL;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_action)
            ACT_LOAD: begin
              if (!sts.len_bad) begin
                cmd.ld_start = 1'b1;
                state_nxt    = ST_LD_BIT;
              end
            end
            ACT_DECODE: begin
              cmd.dec_start = 1'b1;
              state_nxt     = sts.walk_root ? ST_DEC_BIT : ST_DEC_FETCH;
            end
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD_BIT: begin
        if (sts.bits_zero) begin
          cmd.ld_store = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (!sts.slot_zero) begin
          cmd.ld_descend = 1'b1;
          state_nxt      = ST_LD_RD;
        end else if (sts.table_full) begin
          if (can_emit) begin
            cmd.ld_wb     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_TABLE_FULL;
            state_nxt     = ST_FLUSH;
          end
        end else begin
          cmd.ld_alloc = 1'b1;
        end
      end
      ST_LD_RD: begin
        cmd.load_entry = 1'b1;
        state_nxt      = ST_LD_BIT;
      end
      ST_DEC_FETCH: begin
        cmd.load_entry = 1'b1;
        state_nxt      = ST_DEC_BIT;
      end
      ST_DEC_BIT: begin
        if (sts.bits_zero) begin
          state_nxt = ST_FLUSH;
        end else if (sts.skip_nz) begin
          cmd.dec_skip = 1'b1;
        end else if (sts.next_zero) begin
          if (can_emit) begin
            cmd.dec_miss  = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_BAD_PATH;
          end
        end else begin
          cmd.dec_descend = 1'b1;
          state_nxt       = ST_DEC_RD;
        end
      end
      ST_DEC_RD: begin
        if (sts.rd_leaf) begin
          if (can_emit) begin
            cmd.dec_leaf  = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_SYMBOL;
            state_nxt     = ST_DEC_BIT;
          end
        end else begin
          cmd.load_entry = 1'b1;
          state_nxt      = ST_DEC_BIT;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.can_push) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `HTD_ASSERT_IMP(a_emit_room, cmd.emit, !sts.pend_valid || sts.can_push, "emit without room")
  `HTD_ASSERT_IMP(a_idle_drained, state_r == ST_IDLE, !sts.pend_valid, "result held in idle")
  `HTD_ASSERT_NEXT(a_bad_len_idle, in_ready && in_valid && in_action == ACT_LOAD && sts.len_bad, state_r == ST_IDLE, "bad length load left idle")

endmodule

FILE: rtl/core/htd_datapath.sv
// Datapath of the Huffman tree decoder: node table, walk registers and result staging.
module htd_datapath import htd_pkg::*; #(
  parameter int NODE_COUNT      = 512,
  parameter int MAX_CODE_LENGTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_length,
  input  logic [DATA_W-1:0] in_data_byte,
  input  logic              cfg_valid,
  input  logic [PAD_W-1:0]  cfg_padding_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [SYM_W-1:0]  out_symbol_res,
  output logic              out_last
);

  `include "huffman_tree_decoder_unit_assert.svh"

  localparam int IDX_W     = $clog2(NODE_COUNT);
  localparam int CNT_W     = $clog2(NODE_COUNT + 1);
  localparam int ENTRY_W   = 2 * IDX_W + SYM_W;
  localparam int LEN_LIMIT = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;
  localparam int CBIT_W    = $clog2(CODE_W);
  localparam int DBIT_W    = $clog2(DATA_W);

  // Node table: left child, right child, symbol. Entries are written before read.
  logic [ENTRY_W-1:0] mem [NODE_COUNT];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               wr_en;

  logic [ENTRY_W-1:0] root_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [IDX_W-1:0]   ld_node_r;
  logic [IDX_W-1:0]   walk_r;
  logic [CNT_W-1:0]   node_count_r;
  logic [LEN_W-1:0]   bits_left_r;
  logic [PAD_W-1:0]   padding_r;
  logic [PAD_W-1:0]   skip_r;
  logic               started_r;
  logic [SYM_W-1:0]   sym_r;
  logic [CODE_W-1:0]  code_r;
  logic [DATA_W-1:0]  data_r;

  logic               pend_valid_r;
  kind_t              pend_kind_r;
  logic [SYM_W-1:0]   pend_sym_r;
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [SYM_W-1:0]   out_sym_r;
  logic               out_last_r;

  logic [IDX_W-1:0]   ent_left;
  logic [IDX_W-1:0]   ent_right;
  logic [SYM_W-1:0]   ent_sym;
  logic [LEN_W-1:0]   bl_m1;
  logic               ld_bit;
  logic               dec_bit;
  logic [IDX_W-1:0]   ld_slot;
  logic [IDX_W-1:0]   dec_next;
  logic [IDX_W-1:0]   alloc_idx;
  logic               table_full;
  logic               can_push;
  logic               push;
  logic [SYM_W-1:0]   emit_sym;

  assign ent_left  = entry_r[ENTRY_W-1 -: IDX_W];
  assign ent_right = entry_r[SYM_W +: IDX_W];
  assign ent_sym   = entry_r[SYM_W-1:0];
  assign bl_m1     = bits_left_r - LEN_W'(1);
  assign ld_bit    = code_r[bl_m1[CBIT_W-1:0]];
  assign dec_bit   = data_r[bl_m1[DBIT_W-1:0]];
  assign ld_slot   = ld_bit ? ent_right : ent_left;
  assign dec_next  = dec_bit ? ent_right : ent_left;
  assign alloc_idx = node_count_r[IDX_W-1:0];
  assign table_full = (node_count_r >= CNT_W'(NODE_COUNT));

  assign can_push = !out_valid_r || out_ready;
  assign push     = (cmd.emit && pend_valid_r) || cmd.flush;
  assign emit_sym = (cmd.emit_kind == KIND_SYMBOL) ? rd_data_r[SYM_W-1:0] : '0;

  // Memory ports.
  assign wr_en = cmd.ld_alloc || cmd.ld_store || cmd.ld_wb;
  assign rd_en = cmd.ld_descend || cmd.dec_descend || (cmd.dec_start && (walk_r != '0));

  always_comb begin
    if (cmd.ld_descend) begin
      rd_addr = ld_slot;
    end else if (cmd.dec_descend) begin
      rd_addr = dec_next;
    end else begin
      rd_addr = walk_r;
    end
  end

  always_comb begin
    if (cmd.ld_alloc) begin
      wr_data = ld_bit ? {ent_left, alloc_idx, ent_sym} : {alloc_idx, ent_right, ent_sym};
    end else if (cmd.ld_store) begin
      wr_data = {ent_left, ent_right, sym_r};
    end else begin
      wr_data = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ld_node_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r       <= '0;
      node_count_r <= CNT_W'(1);
      walk_r       <= '0;
      started_r    <= 1'b0;
      skip_r       <= '0;
      padding_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        padding_r <= cfg_padding_bits;
      end
      if (cmd.clear) begin
        root_r       <= '0;
        node_count_r <= CNT_W'(1);
        walk_r       <= '0;
        started_r    <= 1'b0;
        skip_r       <= padding_r;
      end
      // The root lives in a register so that it is valid straight out of reset.
      if (wr_en && (ld_node_r == '0)) begin
        root_r <= wr_data;
      end
      if (cmd.ld_alloc) begin
        node_count_r <= node_count_r + CNT_W'(1);
      end
      if (cmd.dec_start && !started_r) begin
        started_r <= 1'b1;
        skip_r    <= padding_r;
      end
      if (cmd.dec_skip) begin
        skip_r <= skip_r - PAD_W'(1);
      end
      if (cmd.dec_miss || cmd.dec_leaf) begin
        walk_r <= '0;
      end else if (cmd.dec_descend) begin
        walk_r <= dec_next;
      end
      if (cmd.emit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_r  <= in_symbol;
      code_r <= in_code_bits;
      data_r <= in_data_byte;
    end
    if (cmd.ld_start) begin
      bits_left_r <= in_code_length;
    end else if (cmd.dec_start) begin
      bits_left_r <= LEN_W'(BYTE_BITS);
    end else if (cmd.ld_alloc || cmd.ld_descend || cmd.dec_skip || cmd.dec_miss ||
                 cmd.dec_descend) begin
      bits_left_r <= bl_m1;
    end
    if (cmd.ld_start) begin
      ld_node_r <= '0;
    end else if (cmd.ld_alloc) begin
      ld_node_r <= alloc_idx;
    end else if (cmd.ld_descend) begin
      ld_node_r <= ld_slot;
    end
    if (cmd.ld_start || cmd.dec_miss || cmd.dec_leaf || (cmd.dec_start && walk_r == '0)) begin
      entry_r <= root_r;
    end else if (cmd.ld_alloc) begin
      entry_r <= '0;
    end else if (cmd.load_entry) begin
      entry_r <= rd_data_r;
    end
    if (cmd.emit) begin
      pend_kind_r <= cmd.emit_kind;
      pend_sym_r  <= emit_sym;
    end
    if (push) begin
      out_kind_r <= pend_kind_r;
      out_sym_r  <= pend_sym_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_symbol_res = out_sym_r;
  assign out_last       = out_last_r;

  always_comb begin
    sts            = '0;
    sts.len_bad    = (in_code_length == '0) || (in_code_length > LEN_W'(LEN_LIMIT));
    sts.walk_root  = (walk_r == '0);
    sts.slot_zero  = (ld_slot == '0);
    sts.table_full = table_full;
    sts.bits_zero  = (bits_left_r == '0);
    sts.skip_nz    = (skip_r != '0);
    sts.next_zero  = (dec_next == '0);
    sts.rd_leaf    = (rd_data_r[ENTRY_W-1:SYM_W] == '0);
    sts.pend_valid = pend_valid_r;
    sts.can_push   = can_push;
  end

  `HTD_ASSERT_ALWAYS(a_count_range, node_count_r >= CNT_W'(1) && node_count_r <= CNT_W'(NODE_COUNT), "node count out of range")
  `HTD_ASSERT_ALWAYS(a_walk_alloc, CNT_W'(walk_r) < node_count_r, "walk node not allocated")
  `HTD_ASSERT_IMP(a_push_room, push, can_push, "result overwrites held output")
  `HTD_ASSERT_IMP(a_alloc_room, cmd.ld_alloc, !table_full, "allocation past table end")

endmodule

FILE: rtl/core/huffman_tree_decoder_unit.sv
// Load request: accepted in idle, then each code bit allocates a new node or descends
// into an existing one via a table read, then stores the symbol or flags a full table.
// Decode request: accepted in idle, with a fetch of the walk node first if the walk is
// inside the tree; each bit is then skipped, misses or descends with a node table read,
// and a flush closes the request; the walk stalls while the result side is full.
// An output register lets a new request in while the last result waits; reset clears the
// control state, the root and the fill count at once, and the node table needs no clearing.
module huffman_tree_decoder_unit import htd_pkg::*; #(
  parameter int NODE_COUNT      = 512,
  parameter int MAX_CODE_LENGTH = 32
) (
  input logic           clk,
  input logic           rst_n,
  htd_in_if.sink        in_ch,
  htd_out_if.source     out_ch,
  htd_cfg_if.sink       cfg_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // The padding register is always writable; the user must change it only while idle.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // The controller sequences one request at a time through the tree walk.
  htd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the node table, walk state and the result staging registers.
  // Each result is held back one step so the final one of a request can carry last.
  htd_datapath #(
    .NODE_COUNT      (NODE_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_symbol        (in_ch.symbol),
    .in_code_bits     (in_ch.code_bits),
    .in_code_length   (in_ch.code_length),
    .in_data_byte     (in_ch.data_byte),
    .cfg_valid        (cfg_ch.valid),
    .cfg_padding_bits (cfg_ch.padding_bits),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_symbol_res   (out_ch.symbol_res),
    .out_last         (out_ch.last)
  );

endmodule

FILE: tb/tb_huffman_tree_decoder_unit.sv
// Self-checking testbench of the Huffman tree decoder: code loads, byte decodes and padding.
module tb_huffman_tree_decoder_unit;
  import htd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT      = 512;
  localparam int MAX_CODE_LENGTH = 32;

  // Action 3 has no meaning; the block must swallow it without a result.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  // A load of a full-length code gives no result, so this
  // many quiet cycles cover any request still in flight once the results have come.
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 500000;

  // One request as it is driven onto the input channel.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [DATA_W-1:0] data_byte;
  } req_t;

  // One result as the block should return it.
  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] symbol_res;
    logic             last;
  } result_t;

  logic clk;
  logic rst_n;

  htd_in_if  in_ch ();
  htd_out_if out_ch ();
  htd_cfg_if cfg_ch ();

  huffman_tree_decoder_unit #(
    .NODE_COUNT      (NODE_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the decoder state. Child index zero means no child, since the root
  // is never anybody's child.
  logic [8:0]       left_link   [NODE_COUNT];
  logic [8:0]       right_link  [NODE_COUNT];
  logic [SYM_W-1:0] leaf_symbol [NODE_COUNT];
  int               nodes_alloc;
  logic [8:0]       walk_at;
  logic [PAD_W-1:0] bits_to_skip;
  logic             stream_live;
  logic [PAD_W-1:0] pad_setting;

  result_t expected_results[$];

  // Prefix code under construction for the well-formed streams.
  logic [CODE_W-1:0] code_value[$];
  int                code_len[$];

  int requests_done;
  int mismatch_count;
  int cycle_count;
  int src_idle_pct;
  int sink_stall_pct;

  // The clock runs from time zero with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The run is bounded so that a hung handshake cannot stall the regression.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The result side stalls at random, at the rate set for the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Every result taken from the block is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d symbol %02h with none expected",
                                  out_ch.kind, out_ch.symbol_res));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, want.kind));
        if (out_ch.symbol_res !== want.symbol_res)
          report_mismatch($sformatf("symbol %02h, expected %02h",
                                    out_ch.symbol_res, want.symbol_res));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, want.last));
      end
    end
  end

  // Back to a lone root with the walk at the root and no stream started.
  task automatic reset_tree();
    for (int i = 0; i < NODE_COUNT; i++) begin
      left_link[i]   = '0;
      right_link[i]  = '0;
      leaf_symbol[i] = '0;
    end
    nodes_alloc = 1;
    walk_at     = '0;
    stream_live = 1'b0;
  endtask

  // Works out the results of one accepted request and files them as expected.
  task automatic predict_request(input req_t r);
    result_t    found[$];
    logic [8:0] node;
    logic [8:0] nxt;
    logic       bit_v;
    logic       stopped;
    case (r.action)
      ACT_LOAD: begin
        // Lengths of zero or beyond the longest code are dropped silently.
        if (r.code_length != 0 && r.code_length <= MAX_CODE_LENGTH) begin
          node    = '0;
          stopped = 1'b0;
          for (int j = int'(r.code_length) - 1; j >= 0 && !stopped; j--) begin
            bit_v = r.code_bits[j];
            nxt   = bit_v ? right_link[node] : left_link[node];
            if (nxt == '0) begin
              // A missing child is allocated unless the table has run out; nodes
              // allocated so far on this walk stay in place.
              if (nodes_alloc >= NODE_COUNT) begin
                found.push_back('{KIND_TABLE_FULL, '0, 1'b0});
                stopped = 1'b1;
              end else begin
                nxt = 9'(nodes_alloc);
                if (bit_v) right_link[node] = nxt;
                else left_link[node] = nxt;
                nodes_alloc++;
              end
            end
            node = nxt;
          end
          if (!stopped) leaf_symbol[node] = r.symbol;
          requests_done++;
        end
      end
      ACT_DECODE: begin
        // The first byte of a stream arms the padding skip.
        if (!stream_live) begin
          bits_to_skip = pad_setting;
          stream_live  = 1'b1;
        end
        for (int i = DATA_W - 1; i >= 0; i--) begin
          if (bits_to_skip != 0) begin
            bits_to_skip--;
          end else begin
            nxt = r.data_byte[i] ? right_link[walk_at] : left_link[walk_at];
            if (nxt == '0) begin
              // Branch into nothing: flag it and restart from the root.
              found.push_back('{KIND_BAD_PATH, '0, 1'b0});
              walk_at = '0;
            end else begin
              walk_at = nxt;
              // Only childless nodes are leaves; a symbol on an inner node stays hidden.
              if (left_link[nxt] == '0 && right_link[nxt] == '0) begin
                found.push_back('{KIND_SYMBOL, leaf_symbol[nxt], 1'b0});
                walk_at = '0;
              end
            end
          end
        end
        requests_done++;
      end
      ACT_CLEAR: begin
        reset_tree();
        bits_to_skip = pad_setting;
        requests_done++;
      end
      default: ;
    endcase
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[k]) expected_results.push_back(found[k]);
  endtask

  // A request of the given action with every field randomized.
  function automatic req_t random_request(input logic [ACT_W-1:0] action);
    req_t r;
    r.action      = action;
    r.symbol      = SYM_W'($urandom);
    r.code_bits   = $urandom;
    r.code_length = LEN_W'($urandom);
    r.data_byte   = DATA_W'($urandom);
    return r;
  endfunction

  // Drives one request at the falling edge and holds it until the block takes it.
  // Valid is left high afterwards; the next request or an idle cycle replaces it.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= r.action;
    in_ch.symbol      <= r.symbol;
    in_ch.code_bits   <= r.code_bits;
    in_ch.code_length <= r.code_length;
    in_ch.data_byte   <= r.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(r);
    @(negedge clk);
  endtask

  // Bits above a short code are don't-care, so they carry random junk.
  task automatic send_load(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                           input logic [LEN_W-1:0] len);
    req_t              r;
    logic [CODE_W-1:0] mask;
    r             = random_request(ACT_LOAD);
    r.symbol      = sym;
    r.code_length = len;
    if (len >= 1 && len < CODE_W) begin
      mask        = (CODE_W'(1) << len) - 1;
      r.code_bits = (code & mask) | (r.code_bits & ~mask);
    end else begin
      r.code_bits = code;
    end
    send_request(r);
  endtask

  task automatic send_decode(input logic [DATA_W-1:0] data);
    req_t r;
    r           = random_request(ACT_DECODE);
    r.data_byte = data;
    send_request(r);
  endtask

  task automatic send_clear();
    send_request(random_request(ACT_CLEAR));
  endtask

  // Stops new requests and waits until every expected result is back, then lets a
  // silent load finish too.
  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The padding register is only written while the block has nothing in hand.
  task automatic write_padding(input logic [PAD_W-1:0] v);
    wait_until_idle();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.padding_bits <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    pad_setting = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Grows a complete prefix code by splitting leaves. The deep form always splits
  // the newest leaf, which gives a chain as long as the leaf count allows.
  task automatic build_prefix_code(input int leaves, input bit deep);
    int                pick;
    logic [CODE_W-1:0] v;
    int                l;
    code_value.delete();
    code_len.delete();
    code_value.push_back('0);
    code_len.push_back(0);
    while (code_len.size() < leaves) begin
      pick = deep ? code_len.size() - 1 : $urandom_range(code_len.size() - 1);
      if (code_len[pick] >= MAX_CODE_LENGTH) break;
      v = code_value[pick];
      l = code_len[pick];
      code_value.delete(pick);
      code_len.delete(pick);
      code_value.push_back(v << 1);
      code_len.push_back(l + 1);
      code_value.push_back((v << 1) | 1'b1);
      code_len.push_back(l + 1);
    end
  endtask

  // Encodes random symbols of the current code into bytes, after the padding bits
  // of a fresh stream, and sends them. The tail of the last byte is random.
  task automatic send_encoded_stream(input int bit_goal);
    bit                stream[$];
    int                pick;
    logic [DATA_W-1:0] b;
    repeat (pad_setting) stream.push_back(1'($urandom_range(1)));
    while (stream.size() < bit_goal) begin
      pick = $urandom_range(code_len.size() - 1);
      for (int k = code_len[pick] - 1; k >= 0; k--) stream.push_back(code_value[pick][k]);
    end
    while (stream.size() % DATA_W != 0) stream.push_back(1'($urandom_range(1)));
    while (stream.size() > 0) begin
      for (int k = DATA_W - 1; k >= 0; k--) b[k] = stream.pop_front();
      send_decode(b);
    end
  endtask

  // A small four-symbol code, decoded across byte edges and with eight results
  // from a single byte.
  task automatic test_tree_walk();
    send_clear();
    send_load(8'hA5, 32'h0, 6'd1);
    send_load(8'h3C, 32'h2, 6'd2);
    send_load(8'hFF, 32'h6, 6'd3);
    send_load(8'h00, 32'h7, 6'd3);
    send_decode(8'b0101_1011);
    send_decode(8'b1000_0000);
    send_decode(8'hFF);
    send_decode(8'h00);
  endtask

  // Hidden inner symbols, overwrites, dropped requests, missing children and
  // full-length codes.
  task automatic test_special_cases();
    // A symbol placed on an inner node must never come out.
    send_load(8'h77, 32'h1, 6'd1);
    send_decode(8'hC0);
    // Reloading a code replaces its symbol.
    send_load(8'h5A, 32'h0, 6'd1);
    send_decode(8'h00);
    // Empty and over-long codes and the spare action are dropped without a result.
    send_load(8'h99, 32'hFFFF_FFFF, 6'd0);
    send_load(8'h99, 32'hFFFF_FFFF, 6'd33);
    send_load(8'h99, 32'hFFFF_FFFF, 6'd63);
    send_request(random_request(ACT_SPARE));
    // With only one leaf every other branch is a missing child.
    send_clear();
    send_load(8'h11, 32'h0, 6'd2);
    send_decode(8'hFF);
    send_decode(8'h80);
    // Full-length codes; the all-zero one turns the earlier leaf into an inner node.
    send_load(8'hEE, 32'hFFFF_FFFF, 6'd32);
    send_load(8'h01, 32'h0, 6'd32);
    repeat (4) send_decode(8'hFF);
  endtask

  // Padding at the top of its range and at a middle value, and kept across a clear.
  task automatic test_padding_skip();
    write_padding(3'd7);
    send_clear();
    send_load(8'h42, 32'h1, 6'd1);
    send_load(8'h24, 32'h0, 6'd1);
    send_decode(8'b1111_1110);
    send_decode(8'hA5);
    write_padding(3'd3);
    send_clear();
    send_load(8'h42, 32'h1, 6'd1);
    send_decode(8'h1F);
  endtask

  // Long codes with spread-out prefixes exhaust the node table.
  task automatic test_table_full();
    logic [CODE_W-1:0] code;
    write_padding(3'd0);
    send_clear();
    for (int k = 0; k < 20; k++) begin
      code = {4'(k), 28'($urandom)};
      send_load(8'(k), code, 6'd32);
    end
    repeat (3) send_decode(DATA_W'($urandom));
    send_clear();
  endtask

  // Mostly complete codes with streams built from them; then partial trees that
  // provoke missing children, loads laid over the current tree, and noise.
  task automatic test_random_streams(input int budget);
    int stop_at;
    int mode;
    bit deep;
    stop_at = requests_done + budget;
    while (requests_done < stop_at) begin
      mode = $urandom_range(99);
      if (mode < 75) begin
        deep = ($urandom_range(99) < 15);
        send_clear();
        build_prefix_code(deep ? $urandom_range(2, 33) : $urandom_range(2, 12), deep);
        for (int i = 0; i < code_len.size(); i++) begin
          // Below 60 the tree is complete; above it some leaves are left out.
          if (mode < 60 || $urandom_range(99) < 60)
            send_load(SYM_W'($urandom), code_value[i], LEN_W'(code_len[i]));
        end
        send_encoded_stream(DATA_W * $urandom_range(1, 10));
      end else if (mode < 90) begin
        repeat ($urandom_range(1, 4))
          send_load(SYM_W'($urandom), $urandom, LEN_W'($urandom_range(1, MAX_CODE_LENGTH)));
        repeat ($urandom_range(1, 4)) send_decode(DATA_W'($urandom));
      end else begin
        case ($urandom_range(3))
          0: send_load(SYM_W'($urandom), $urandom,
                       $urandom_range(1) ? LEN_W'(0) : LEN_W'($urandom_range(33, 63)));
          1: send_request(random_request(ACT_SPARE));
          2: send_clear();
          default: send_decode(DATA_W'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    // Every input is known from time zero, with reset held low at first.
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_CLEAR;
    in_ch.symbol        = '0;
    in_ch.code_bits     = '0;
    in_ch.code_length   = '0;
    in_ch.data_byte     = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.padding_bits = '0;
    requests_done       = 0;
    mismatch_count      = 0;
    cycle_count         = 0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    pad_setting         = '0;
    bits_to_skip        = '0;
    reset_tree();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First phase: the sender rarely pauses and the receiver mostly stalls.
    src_idle_pct   = 6;
    sink_stall_pct = 78;
    write_padding(3'd0);
    test_tree_walk();
    test_special_cases();
    test_padding_skip();
    test_table_full();
    write_padding(3'd5);
    test_random_streams(120);

    // Second phase: the roles swap.
    src_idle_pct   = 78;
    sink_stall_pct = 6;
    write_padding(3'd7);
    test_random_streams(120);

    // Last phase: both sides at full speed.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_padding(3'($urandom));
    test_random_streams(115);

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
